@@ src/bsil_pkg.sv @@
// ----------------------------------------------------------------------------
// bsil_pkg
// shared constants and helpers for the marker bit index and line number block
// ----------------------------------------------------------------------------
package bsil_pkg;

    localparam int WORD_BITS = 64;
    localparam int FIELD_W   = 64;
    localparam int CHUNK     = 8;
    localparam int CHUNK_W   = $clog2(CHUNK);
    localparam int N_CHUNKS  = (WORD_BITS + CHUNK - 1) / CHUNK;
    localparam int PAD_BITS  = N_CHUNKS * CHUNK;
    localparam int CIDX_W    = (N_CHUNKS > 1) ? $clog2(N_CHUNKS) : 1;
    localparam int OFF_W     = CIDX_W + CHUNK_W;
    localparam int CNT_W     = $clog2(CHUNK + 1);

    typedef logic [CHUNK-1:0]    t_chunk;
    typedef logic [PAD_BITS-1:0] t_pad;
    typedef logic [FIELD_W-1:0]  t_field;

    // lowest set bit of a chunk, zero when empty
    function automatic logic [CHUNK_W-1:0] f_lowest(input t_chunk v);
        logic [CHUNK_W-1:0] r;
        r = '0;
        for (int k = CHUNK - 1; k >= 0; k--) begin
            if (v[k]) begin
                r = CHUNK_W'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] f_count(input t_chunk v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int k = 0; k < CHUNK; k++) begin
            n = n + CNT_W'(v[k]);
        end
        return n;
    endfunction

endpackage

@@ src/bsil_if.sv @@
// ----------------------------------------------------------------------------
// bsil_in_if / bsil_out_if
// valid/ready channels carrying input words and position results
// ----------------------------------------------------------------------------
interface bsil_in_if;
    logic                  valid;
    logic                  ready;
    bsil_pkg::t_field      marker_bits;
    bsil_pkg::t_field      break_bits;

    modport source (output valid, output marker_bits, output break_bits, input ready);
    modport sink   (input valid, input marker_bits, input break_bits, output ready);
endinterface

interface bsil_out_if;
    logic                  valid;
    logic                  ready;
    bsil_pkg::t_field      position;
    bsil_pkg::t_field      line_number;
    logic                  last_of_word;

    modport source (output valid, output position, output line_number,
                    output last_of_word, input ready);
    modport sink   (input valid, input position, input line_number,
                    input last_of_word, output ready);
endinterface

@@ src/bit_scan_index_line_number.sv @@
// ----------------------------------------------------------------------------
// bit_scan_index_line_number
// emits absolute position and line number of every set marker bit
// ----------------------------------------------------------------------------
// i_in takes one item: a marker word and the aligned line-break word.
// o_out gives one item per set marker bit, lowest first: its absolute bit
// position, the count of break bits before it, and a flag on the last item
// of the word. A word with no marker bits gives no item.
// After an input item is accepted the block walks the word one 8-bit chunk
// per cycle through a single scan unit, holding on a chunk with a marker bit;
// such a chunk yields one item per cycle while the output register is free
// (empty or being taken) until its markers are used, then the walk moves on.
// A new word is not taken until the walk of the current one ends.
// i_in.ready is high only between words.
// Results pass through an output register; while o_out.ready is low the
// held item stays and the scan waits on its next result.
// Reset clears the word base and line counter to zero and empties the
// output register.
// ----------------------------------------------------------------------------
module bit_scan_index_line_number (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bsil_in_if.sink           i_in,
    bsil_out_if.source        o_out
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                            r_state, n_state;
    bsil_pkg::t_pad                  r_marks, n_marks;
    bsil_pkg::t_pad                  r_breaks, n_breaks;
    logic [bsil_pkg::CIDX_W-1:0]     r_cidx, n_cidx;
    bsil_pkg::t_field                r_word_base, n_word_base;
    bsil_pkg::t_field                r_line, n_line;
    logic                            r_o_valid, n_o_valid;
    bsil_pkg::t_field                r_pos, n_pos;
    bsil_pkg::t_field                r_line_out, n_line_out;
    logic                            r_last, n_last;

    bsil_pkg::t_chunk                w_mchunk;
    bsil_pkg::t_chunk                w_bchunk;
    logic [bsil_pkg::CHUNK_W-1:0]    w_bit;
    bsil_pkg::t_chunk                w_below;
    bsil_pkg::t_chunk                w_onehot;
    bsil_pkg::t_pad                  w_cleared;
    logic [bsil_pkg::OFF_W-1:0]      w_off;
    logic                            w_slot_free;

    assign w_mchunk    = r_marks[bsil_pkg::CHUNK-1:0];
    assign w_bchunk    = r_breaks[bsil_pkg::CHUNK-1:0];
    assign w_bit       = bsil_pkg::f_lowest(w_mchunk);
    assign w_onehot    = bsil_pkg::t_chunk'(1) << w_bit;
    assign w_below     = w_onehot - bsil_pkg::t_chunk'(1);
    assign w_cleared   = r_marks & ~bsil_pkg::t_pad'(w_onehot);
    assign w_off       = (bsil_pkg::OFF_W'(r_cidx) << bsil_pkg::CHUNK_W)
                       | bsil_pkg::OFF_W'(w_bit);
    assign w_slot_free = !r_o_valid || o_out.ready;

    always_comb begin
        n_state     = r_state;
        n_marks     = r_marks;
        n_breaks    = r_breaks;
        n_cidx      = r_cidx;
        n_word_base = r_word_base;
        n_line      = r_line;
        n_o_valid   = r_o_valid && !o_out.ready;
        n_pos       = r_pos;
        n_line_out  = r_line_out;
        n_last      = r_last;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_marks  = bsil_pkg::t_pad'(i_in.marker_bits[bsil_pkg::WORD_BITS-1:0]);
                    n_breaks = bsil_pkg::t_pad'(i_in.break_bits[bsil_pkg::WORD_BITS-1:0]);
                    n_cidx   = '0;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_mchunk != '0) begin
                    if (w_slot_free) begin
                        n_o_valid  = 1'b1;
                        n_pos      = r_word_base + bsil_pkg::FIELD_W'(w_off);
                        n_line_out = r_line
                                   + bsil_pkg::FIELD_W'(bsil_pkg::f_count(w_bchunk & w_below));
                        n_last     = (w_cleared == '0);
                        n_marks    = w_cleared;
                    end
                end else begin
                    n_line   = r_line + bsil_pkg::FIELD_W'(bsil_pkg::f_count(w_bchunk));
                    n_marks  = r_marks >> bsil_pkg::CHUNK;
                    n_breaks = r_breaks >> bsil_pkg::CHUNK;
                    if (r_cidx == bsil_pkg::CIDX_W'(bsil_pkg::N_CHUNKS - 1)) begin
                        n_word_base = r_word_base + bsil_pkg::FIELD_W'(bsil_pkg::WORD_BITS);
                        n_state     = ST_IDLE;
                    end else begin
                        n_cidx = r_cidx + bsil_pkg::CIDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_word_base <= '0;
            r_line      <= '0;
            r_o_valid   <= 1'b0;
            r_cidx      <= '0;
        end else begin
            r_state     <= n_state;
            r_word_base <= n_word_base;
            r_line      <= n_line;
            r_o_valid   <= n_o_valid;
            r_cidx      <= n_cidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_marks    <= n_marks;
        r_breaks   <= n_breaks;
        r_pos      <= n_pos;
        r_line_out <= n_line_out;
        r_last     <= n_last;
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_o_valid;
    assign o_out.position     = r_pos;
    assign o_out.line_number  = r_line_out;
    assign o_out.last_of_word = r_last;

endmodule

@@ src/bsil_checker.sv @@
// ----------------------------------------------------------------------------
// bsil_checker
// port-level checks for the marker bit index and line number block
// ----------------------------------------------------------------------------
module bsil_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic                   i_out_last,
    input bsil_pkg::t_field       i_out_position,
    input bsil_pkg::t_field       i_out_line_number
);

    // busy once a word is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready straight after accept");

    // a word is not finished while a non-last item is pending
    a_word_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input ready with word results outstanding");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_position) && $stable(i_out_line_number) && $stable(i_out_last))
        else $error("output item changed while stalled");

endmodule

bind bit_scan_index_line_number bsil_checker u_bsil_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_last       (o_out.last_of_word),
    .i_out_position   (o_out.position),
    .i_out_line_number(o_out.line_number)
);
